[sv/bgcd_pkg.sv]
// Shared types for the binary GCD unit: controller states, datapath commands and status.
`default_nettype none

package bgcd_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TWOS,
    ST_ODDA,
    ST_REDUCE,
    ST_RESTORE,
    ST_DONE
  } gcd_state_e;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_LOAD,
    CMD_OR,
    CMD_HALVE_BOTH,
    CMD_HALVE_A,
    CMD_HALVE_B,
    CMD_SUB,
    CMD_DOUBLE_A
  } gcd_cmd_e;

  typedef struct packed {
    logic a_zero;
    logic b_zero;
    logic a_odd;
    logic b_odd;
    logic k_zero;
  } gcd_status_t;

endpackage

`default_nettype wire

[sv/bgcd_datapath.sv]
// Operand registers, shared-power counter and the subtract/shift datapath.
`default_nettype none

module bgcd_datapath import bgcd_pkg::*; #(
  parameter int DATA_WIDTH = 63
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire gcd_cmd_e              cmd_i,
  input  wire logic [DATA_WIDTH-1:0] first_operand_i,
  input  wire logic [DATA_WIDTH-1:0] second_operand_i,
  output gcd_status_t                status_o,
  output logic [DATA_WIDTH-1:0]      result_o
);

  localparam int KW = $clog2(DATA_WIDTH);

  logic [DATA_WIDTH-1:0] a_q, a_d, b_q, b_d;
  logic [KW-1:0]         k_q, k_d;
  logic                  a_lt_b;
  logic [DATA_WIDTH:0]   diff_ab, diff_ba;

  // both differences side by side; the borrow of a - b picks the larger
  assign diff_ab = {1'b0, a_q} - {1'b0, b_q};
  assign diff_ba = {1'b0, b_q} - {1'b0, a_q};
  assign a_lt_b  = diff_ab[DATA_WIDTH];

  always_comb begin
    a_d = a_q;
    b_d = b_q;
    k_d = k_q;
    unique case (cmd_i)
      CMD_HOLD: ;
      CMD_LOAD: begin
        a_d = first_operand_i;
        b_d = second_operand_i;
        k_d = '0;
      end
      CMD_OR:  a_d = a_q | b_q;
      CMD_HALVE_BOTH: begin
        a_d = a_q >> 1;
        b_d = b_q >> 1;
        k_d = k_q + KW'(1);
      end
      CMD_HALVE_A: a_d = a_q >> 1;
      CMD_HALVE_B: b_d = b_q >> 1;
      // keep the smaller odd value, replace the other by the difference
      CMD_SUB: begin
        if (a_lt_b) begin
          a_d = a_q;
          b_d = diff_ba[DATA_WIDTH-1:0];
        end else begin
          a_d = b_q;
          b_d = diff_ab[DATA_WIDTH-1:0];
        end
      end
      CMD_DOUBLE_A: begin
        a_d = a_q << 1;
        k_d = k_q - KW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else begin
      k_q <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
  end

  assign status_o.a_zero = (a_q == '0);
  assign status_o.b_zero = (b_q == '0);
  assign status_o.a_odd  = a_q[0];
  assign status_o.b_odd  = b_q[0];
  assign status_o.k_zero = (k_q == '0);
  assign result_o        = a_q;

endmodule

`default_nettype wire

[sv/bgcd_ctrl.sv]
// Sequencer for the binary GCD: strips twos, reduces, restores the shared power.
`default_nettype none

module bgcd_ctrl import bgcd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  output logic             done_o,
  input  wire gcd_status_t status_i,
  output gcd_cmd_e         cmd_o
);

  gcd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_HOLD;
    busy    = 1'b1;
    done_o  = 1'b0;
    unique case (state_q)
      ST_IDLE, ST_DONE: begin
        busy   = 1'b0;
        done_o = (state_q == ST_DONE);
        if (start) begin
          cmd_o   = CMD_LOAD;
          state_d = ST_TWOS;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_TWOS: begin
        priority if (status_i.a_zero || status_i.b_zero) begin
          cmd_o   = CMD_OR;
          state_d = ST_RESTORE;
        end else if (!status_i.a_odd && !status_i.b_odd) begin
          cmd_o = CMD_HALVE_BOTH;
        end else begin
          state_d = ST_ODDA;
        end
      end
      ST_ODDA: begin
        if (!status_i.a_odd) begin
          cmd_o = CMD_HALVE_A;
        end else begin
          state_d = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        priority if (status_i.b_zero) begin
          state_d = ST_RESTORE;
        end else if (!status_i.b_odd) begin
          cmd_o = CMD_HALVE_B;
        end else begin
          cmd_o = CMD_SUB;
        end
      end
      ST_RESTORE: begin
        if (status_i.k_zero) begin
          state_d = ST_DONE;
        end else begin
          cmd_o = CMD_DOUBLE_A;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[sv/binary_gcd64_unit.sv]
// Binary (Stein) GCD unit: one request in, one result strobed out.
// A request is taken when start is high and busy is low. The unit halves both
// operands while both are even (counting the shared power of two), makes the
// first odd, then per cycle either halves the second operand or replaces the
// larger by the difference, one shift or one subtract a cycle, and finally
// doubles the result back once per counted two. If either operand is zero, the
// result is the OR of the two operands.
// The result shows on gcd_value_o when done_o is high for exactly one cycle; it
// stays there until the next request is loaded, and the receiver cannot stall.
// busy is low in that cycle, so the next request may be taken while the result
// is shown.
`default_nettype none

module binary_gcd64_unit import bgcd_pkg::*; #(
  parameter int DATA_WIDTH = 63
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [DATA_WIDTH-1:0] first_operand_i,
  input  wire logic [DATA_WIDTH-1:0] second_operand_i,
  output logic                       done_o,
  output logic [DATA_WIDTH-1:0]      gcd_value_o
);

  gcd_cmd_e    cmd;
  gcd_status_t status;

  bgcd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .done_o   (done_o),
    .status_i (status),
    .cmd_o    (cmd)
  );

  bgcd_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .first_operand_i  (first_operand_i),
    .second_operand_i (second_operand_i),
    .status_o         (status),
    .result_o         (gcd_value_o)
  );

endmodule

`default_nettype wire
